[sv/rmw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rmw_pkg;

    // Data path width in bytes and the largest access size the block takes
    localparam int DATA_BYTES = 8;
    localparam int MAX_BYTES  = 8;
    localparam int DATA_W     = DATA_BYTES * 8;
    localparam int SIZE_W     = 4;
    localparam int CODE_W     = 4;

    // Largest legal access size: the smaller of the limit and the data path
    localparam logic [SIZE_W-1:0] SIZE_LIMIT =
        SIZE_W'((MAX_BYTES < DATA_BYTES) ? MAX_BYTES : DATA_BYTES);

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [SIZE_W-1:0] size_t;

    // Operation codes
    typedef enum logic [CODE_W-1:0] {
        OP_XCHG = 4'd0,
        OP_ADD  = 4'd1,
        OP_SUB  = 4'd2,
        OP_AND  = 4'd3,
        OP_NAND = 4'd4,
        OP_OR   = 4'd5,
        OP_XOR  = 4'd6,
        OP_MAX  = 4'd7,
        OP_MIN  = 4'd8,
        OP_UMAX = 4'd9,
        OP_UMIN = 4'd10
    } op_t;

    // Byte mask covering the low size bytes
    function automatic data_t width_mask(input size_t size);
        data_t m;
        m = '0;
        for (int i = 0; i < DATA_BYTES; i++) begin
            if (SIZE_W'(i) < size)
            begin
                m[i*8 +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

    // Single bit at the top of the access width
    function automatic data_t sign_bit(input size_t size);
        data_t s;
        s = '0;
        for (int i = 0; i < DATA_BYTES; i++) begin
            if (SIZE_W'(i + 1) == size)
            begin
                s[i*8 + 7] = 1'b1;
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

[sv/rmw_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rmw_req_if;
    logic                                valid;
    logic                                ready;
    logic [rmw_pkg::CODE_W-1:0]          req_type;
    rmw_pkg::size_t                      size_bytes;
    rmw_pkg::data_t                      old_value;
    rmw_pkg::data_t                      operand_value;

    modport source (
        output valid, req_type, size_bytes, old_value, operand_value,
        input  ready
    );

    modport sink (
        input  valid, req_type, size_bytes, old_value, operand_value,
        output ready
    );
endinterface

`default_nettype wire

[sv/rmw_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rmw_rsp_if;
    logic           valid;
    logic           ready;
    rmw_pkg::data_t new_value;
    logic           op_error;

    modport source (
        output valid, new_value, op_error,
        input  ready
    );

    modport sink (
        input  valid, new_value, op_error,
        output ready
    );
endinterface

`default_nettype wire

[sv/atomic_rmw_alu.sv]
// Atomic read-modify-write ALU.
// Request channel (req): operation code, access size in bytes, the old
// memory value and the operand. Response channel (rsp): the value to write
// back, upper bytes beyond the access size cleared, and an error flag for an
// unknown code or a size outside 1 to the byte limit (value then zero).
// Both channels use valid/ready; a request moves on a clock edge with
// both high.
// Structure: input register, one pass of ALU logic, result register.
// A request accepted at one edge enters the input register, passes the ALU and
// lands in the result register, which drives rsp; one request per cycle is sustained while rsp.ready stays high.
// When the receiver stalls, the result register holds its response and the
// input register still takes one more request; req.ready drops only when
// both registers are full and rsp.ready is low.
// Reset (rst_n low, asynchronous) empties both registers; there is no other
// state.
`timescale 1ns / 1ps
`default_nettype none

module atomic_rmw_alu (
    input  wire logic clk,
    input  wire logic rst_n,
    rmw_req_if.sink   req,
    rmw_rsp_if.source rsp
);
    import rmw_pkg::*;

    // Input stage
    logic                 in_valid_reg;
    logic [CODE_W-1:0]    code_reg;
    size_t                size_reg;
    data_t                old_reg;
    data_t                opnd_reg;

    // Result stage
    logic                 out_valid_reg;
    data_t                result_reg;
    logic                 error_reg;
    data_t                result_next;
    logic                 error_next;

    logic                 out_load;
    logic                 in_load;

    // Pipeline flow control
    assign out_load  = !out_valid_reg || rsp.ready;
    assign req.ready = !in_valid_reg || out_load;
    assign in_load   = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            code_reg <= req.req_type;
            size_reg <= req.size_bytes;
            old_reg  <= req.old_value;
            opnd_reg <= req.operand_value;
        end
        if (out_load && in_valid_reg)
        begin
            result_reg <= result_next;
            error_reg  <= error_next;
        end
    end

    // ALU
    data_t mask;
    data_t sbit;
    data_t a;
    data_t b;
    logic  size_ok;
    logic  u_ge;
    logic  u_le;
    logic  s_ge;
    logic  s_le;
    data_t r;
    logic  bad_code;

    always_comb
    begin
        mask    = width_mask(size_reg);
        sbit    = sign_bit(size_reg);
        a       = old_reg & mask;
        b       = opnd_reg & mask;
        size_ok = (size_reg != '0) && (size_reg <= SIZE_LIMIT);
        u_ge    = a >= b;
        u_le    = a <= b;
        // flipping the sign bit lets an unsigned compare give the signed result
        s_ge    = (a ^ sbit) >= (b ^ sbit);
        s_le    = (a ^ sbit) <= (b ^ sbit);
        bad_code = 1'b0;
        case (op_t'(code_reg))
            OP_XCHG: r = b;
            OP_ADD:  r = a + b;
            OP_SUB:  r = a - b;
            OP_AND:  r = a & b;
            OP_NAND: r = ~(a & b);
            OP_OR:   r = a | b;
            OP_XOR:  r = a ^ b;
            OP_MAX:  r = s_ge ? a : b;
            OP_MIN:  r = s_le ? a : b;
            OP_UMAX: r = u_ge ? a : b;
            OP_UMIN: r = u_le ? a : b;
            default:
            begin
                r        = '0;
                bad_code = 1'b1;
            end
        endcase
        error_next  = bad_code || !size_ok;
        result_next = error_next ? '0 : (r & mask);
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.new_value = result_reg;
    assign rsp.op_error  = error_reg;

endmodule

`default_nettype wire

[sv/rmw_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module rmw_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_ready,
    input wire logic          rsp_valid,
    input wire logic          rsp_ready,
    input wire rmw_pkg::data_t new_value,
    input wire logic          op_error
);
    import rmw_pkg::*;

    // A stalled response keeps its contents
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(new_value) && $stable(op_error))
        else $error("response changed while stalled");

    // An error response carries a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && op_error |-> new_value == '0)
        else $error("error response with non-zero value");

    // With no response pending the block always takes a request
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request refused with empty output");

    // A response cannot appear from nothing: a quiet spell with no request taken and no response gives none
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_valid && req_ready) && !rsp_valid ##1
        !(req_valid && req_ready) && !rsp_valid |=> !rsp_valid)
        else $error("response without request");

endmodule

bind atomic_rmw_alu rmw_checker u_rmw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .new_value (rsp.new_value),
    .op_error  (rsp.op_error)
);

`default_nettype wire
